FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/bfdh_pkg.sv
`default_nettype none
package bfdh_pkg;
    localparam int MAX_BITS         = 65536;
    localparam int MAX_HASHES       = 32;
    localparam int BITS_PER_BYTE    = 8;
    localparam int STORE_BYTES      = MAX_BITS / BITS_PER_BYTE;
    localparam int ADDR_W           = $clog2(STORE_BYTES);
    localparam int IDX_W            = $clog2(MAX_BITS);
    localparam int BIT_W            = $clog2(BITS_PER_BYTE);
    localparam int TOTAL_W          = 17;
    localparam int K_W              = 6;
    localparam int M_W              = 17;
    localparam int HASH_W           = 64;
    localparam int DIGITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES       = HASH_W / DIGITS_PER_CYCLE;
    localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 17;
    localparam int IN_TDATA_W       = 128;
    localparam int OUT_TDATA_W      = 24;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HASH_COUNT   = 1'b0,
        REG_BUCKET_COUNT = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic sweep;
        logic div_start;
        logic check;
        logic emit;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic div_done;
        logic idx_last;
        logic bit_hit;
        logic sweep_last;
    } t_dp_stat;
endpackage
`default_nettype wire

FILE: sv/bloom_filter_double_hash_core.sv
`default_nettype none
// Bloom filter bit store of 65536 bits with double hashing. Each input beat carries a
// command in tuser (insert, query, clear, none) and the two 64-bit hash words in tdata;
// each yields one output beat with the membership flag and the population of set bits.
// Index i is (first + i*second) mod 2^64, reduced modulo bucket_count by a shared unit
// that retires four dividend bits a cycle; each index then takes a read-modify-write on
// the single-port byte memory, and a query stops at the first clear bit. A clear sweeps
// all 8192 bytes, one a cycle, and the same sweep runs after reset, during which no
// input beat is taken. Configuration writes are taken at any time and should be made
// while the block is idle.
module bloom_filter_double_hash_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [63:0] hash_first, [127:64] hash_second
    input  wire logic [bfdh_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [1:0] command
    input  wire logic [1:0]                        i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [16:0] set_bit_total, [23:17] zero
    output logic [bfdh_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // [0] is_member
    output logic                                   o_m_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bfdh_pkg::*;

    logic [K_W-1:0]     r_hash_count;
    logic [M_W-1:0]     r_bucket_count;
    logic [K_W-1:0]     k_eff;
    logic [M_W-1:0]     m_eff;
    logic               r_out_valid;
    logic               r_out_member;
    logic [TOTAL_W-1:0] r_out_total;
    logic               out_free;
    t_dp_ctrl           ctrl;
    t_dp_stat           stat;
    logic               member;
    logic [TOTAL_W-1:0] total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count   <= K_W'(7);
            r_bucket_count <= M_W'(MAX_BITS);
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_HASH_COUNT:   r_hash_count   <= i_cfg_data[K_W-1:0];
                REG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[M_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        k_eff = (r_hash_count > K_W'(MAX_HASHES)) ? K_W'(MAX_HASHES) : r_hash_count;
        if (r_bucket_count < M_W'(BITS_PER_BYTE)) begin
            m_eff = M_W'(BITS_PER_BYTE);
        end else if (r_bucket_count > M_W'(MAX_BITS)) begin
            m_eff = M_W'(MAX_BITS);
        end else begin
            m_eff = r_bucket_count;
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    bfdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_cmd   (t_cmd'(i_s_tuser)),
        .i_k_zero   (k_eff == '0),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_ctrl     (ctrl)
    );

    bfdh_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_cmd    (t_cmd'(i_s_tuser)),
        .i_first  (i_s_tdata[HASH_W-1:0]),
        .i_second (i_s_tdata[2*HASH_W-1:HASH_W]),
        .i_k      (k_eff),
        .i_m      (m_eff),
        .o_stat   (stat),
        .o_member (member),
        .o_total  (total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out_member <= member;
            r_out_total  <= total;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_member;
    assign o_m_tdata  = {(OUT_TDATA_W - TOTAL_W)'(0), r_out_total};
endmodule
`default_nettype wire

FILE: sv/bfdh_mod_unit.sv
`default_nettype none
module bfdh_mod_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [bfdh_pkg::HASH_W-1:0]  i_dividend,
    input  wire logic [bfdh_pkg::M_W-1:0]     i_modulus,
    output logic                              o_done,
    output logic [bfdh_pkg::IDX_W-1:0]        o_rem
);
    import bfdh_pkg::*;
    `include "assert_macros.svh"

    logic [HASH_W-1:0]    r_q;
    logic [M_W-1:0]       r_r;
    logic [M_W-1:0]       n_r;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // Four restoring steps per cycle; the remainder stays below the modulus while the modulus is held.
    always_comb begin
        logic [M_W:0] t;
        n_r = r_r;
        t   = '0;
        for (int j = 0; j < DIGITS_PER_CYCLE; j++) begin
            t = {n_r, r_q[HASH_W-1-j]};
            if (t >= {1'b0, i_modulus}) begin
                n_r = M_W'(t - {1'b0, i_modulus});
            end else begin
                n_r = M_W'(t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
        end else if (r_busy) begin
            r_q <= r_q << DIGITS_PER_CYCLE;
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_r[IDX_W-1:0];

    `ASSERT_IMPLIES(a_rem_below_mod, i_clk, i_rst_n, r_done, r_r < i_modulus)
    `ASSERT_IMPLIES(a_no_start_busy, i_clk, i_rst_n, i_start, !r_busy)
endmodule
`default_nettype wire

FILE: sv/bfdh_datapath.sv
`default_nettype none
module bfdh_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bfdh_pkg::t_dp_ctrl           i_ctrl,
    input  wire bfdh_pkg::t_cmd               i_cmd,
    input  wire logic [bfdh_pkg::HASH_W-1:0]  i_first,
    input  wire logic [bfdh_pkg::HASH_W-1:0]  i_second,
    input  wire logic [bfdh_pkg::K_W-1:0]     i_k,
    input  wire logic [bfdh_pkg::M_W-1:0]     i_m,
    output bfdh_pkg::t_dp_stat                o_stat,
    output logic                              o_member,
    output logic [bfdh_pkg::TOTAL_W-1:0]      o_total
);
    import bfdh_pkg::*;
    `include "assert_macros.svh"

    t_cmd                    r_cmd;
    logic [HASH_W-1:0]       r_h;
    logic [HASH_W-1:0]       r_stride;
    logic [K_W-1:0]          r_cnt;
    logic                    r_member;
    logic [TOTAL_W-1:0]      r_pop;
    logic [ADDR_W-1:0]       r_sweep;
    logic [BITS_PER_BYTE-1:0] r_rdata;
    logic [BITS_PER_BYTE-1:0] mem [STORE_BYTES];

    logic                    div_done;
    logic [IDX_W-1:0]        idx;
    logic                    hit;
    logic                    set_bit;
    logic                    we;
    logic [ADDR_W-1:0]       addr;
    logic [BITS_PER_BYTE-1:0] wdata;

    bfdh_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_dividend (r_h),
        .i_modulus  (i_m),
        .o_done     (div_done),
        .o_rem      (idx)
    );

    assign hit     = r_rdata[idx[BIT_W-1:0]];
    assign set_bit = i_ctrl.check && (r_cmd == CMD_INSERT) && !hit;
    assign we      = i_ctrl.sweep || set_bit;
    assign addr    = i_ctrl.sweep ? r_sweep : idx[IDX_W-1:BIT_W];
    assign wdata   = i_ctrl.sweep ? '0
                   : (r_rdata | (BITS_PER_BYTE'(1) << idx[BIT_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop   <= '0;
            r_sweep <= '0;
        end else begin
            if (i_ctrl.sweep) begin
                r_sweep <= r_sweep + 1'b1;
                r_pop   <= '0;
            end else if (set_bit) begin
                r_pop <= r_pop + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd    <= i_cmd;
            r_h      <= i_first;
            r_stride <= i_second;
            r_cnt    <= '0;
            r_member <= (i_cmd == CMD_QUERY);
        end else if (i_ctrl.check) begin
            r_h   <= r_h + r_stride;
            r_cnt <= r_cnt + 1'b1;
            if ((r_cmd == CMD_QUERY) && !hit) begin
                r_member <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.div_done   = div_done;
        o_stat.idx_last   = (K_W'(r_cnt + 1'b1) == i_k);
        o_stat.bit_hit    = hit;
        o_stat.sweep_last = &r_sweep;
    end

    assign o_member = r_member;
    assign o_total  = r_pop;

    `ASSERT_ALWAYS(a_pop_bound, i_clk, i_rst_n, r_pop <= TOTAL_W'(MAX_BITS))
    `ASSERT_IMPLIES(a_sweep_no_set, i_clk, i_rst_n, i_ctrl.sweep, !i_ctrl.check)
endmodule
`default_nettype wire

FILE: sv/bfdh_ctrl.sv
`default_nettype none
module bfdh_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire bfdh_pkg::t_cmd     i_in_cmd,
    input  wire logic               i_k_zero,
    input  wire logic               i_out_free,
    input  wire bfdh_pkg::t_dp_stat i_stat,
    output logic                    o_in_ready,
    output bfdh_pkg::t_dp_ctrl      o_ctrl
);
    import bfdh_pkg::*;
    `include "assert_macros.svh"

    t_state r_state;
    t_state n_state;
    logic   r_clr_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.sweep_last) begin
                    n_state = r_clr_res ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_NONE:  n_state = ST_DONE;
                        default:   n_state = i_k_zero ? ST_DONE : ST_START;
                    endcase
                end
            end
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_stat.idx_last || ((i_stat.cmd == CMD_QUERY) && !i_stat.bit_hit)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        o_ctrl.load      = (r_state == ST_IDLE) && i_in_valid;
        o_ctrl.sweep     = (r_state == ST_CLEAR);
        o_ctrl.div_start = (r_state == ST_START);
        o_ctrl.check     = (r_state == ST_CHECK);
        o_ctrl.emit      = (r_state == ST_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_res <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctrl.load) begin
                r_clr_res <= (i_in_cmd == CMD_CLEAR);
            end
        end
    end

    `ASSERT_IMPLIES(a_emit_free, i_clk, i_rst_n, o_ctrl.emit, i_out_free)
endmodule
`default_nettype wire

FILE: test/bloom_check.sv
// Watches the three channels of the bloom filter core, keeps its own copy of the
// bit store and population, and compares every output beat with the oldest answer due.
module bloom_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    input  wire logic [bfdh_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic [1:0]                        i_s_tuser,
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [bfdh_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    input  wire logic                              i_m_tuser,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              i_cfg_ready,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                     o_fails,
    output int                                     o_due,
    output int                                     o_answered
);
    import bfdh_pkg::*;

    typedef struct packed {
        logic                member;
        logic [TOTAL_W-1:0]  total;
    } t_answer;

    t_answer          answers_due[$];
    bit               filter_bits [0:MAX_BITS-1];
    int unsigned      bits_set;
    logic [K_W-1:0]   hash_count;
    logic [M_W-1:0]   bucket_count;

    // Applies one command to the local copy of the store and returns its answer.
    function automatic t_answer run_command(t_cmd cmd, logic [63:0] base, logic [63:0] stride);
        t_answer     ans;
        int unsigned k;
        int unsigned m;
        int unsigned n;
        logic [63:0] h;
        m = bucket_count;
        if (m < BITS_PER_BYTE) m = BITS_PER_BYTE;
        if (m > MAX_BITS) m = MAX_BITS;
        k = hash_count;
        if (k > MAX_HASHES) k = MAX_HASHES;
        ans.member = 1'b0;
        case (cmd)
            CMD_INSERT: begin
                for (int i = 0; i < k; i++) begin
                    h = base + 64'(i) * stride;
                    n = 32'(h % 64'(m));
                    if (!filter_bits[n]) begin
                        filter_bits[n] = 1'b1;
                        bits_set++;
                    end
                end
            end
            CMD_QUERY: begin
                ans.member = 1'b1;
                for (int i = 0; i < k; i++) begin
                    h = base + 64'(i) * stride;
                    n = 32'(h % 64'(m));
                    if (!filter_bits[n]) begin
                        ans.member = 1'b0;
                        break;
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < MAX_BITS; i++) filter_bits[i] = 1'b0;
                bits_set = 0;
            end
            default: ;
        endcase
        ans.total = bits_set[TOTAL_W-1:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BITS; i++) filter_bits[i] = 1'b0;
            bits_set = 0;
            hash_count = 6'd7;
            bucket_count = 17'd65536;
            answers_due.delete();
            o_fails <= 0;
            o_answered <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_HASH_COUNT:   hash_count = i_cfg_data[K_W-1:0];
                    REG_BUCKET_COUNT: bucket_count = i_cfg_data[M_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                answers_due.push_back(run_command(t_cmd'(i_s_tuser), i_s_tdata[63:0],
                                                  i_s_tdata[127:64]));
            if (i_m_tvalid && i_m_tready) begin
                if (answers_due.size() == 0) begin
                    $error("output beat with no answer due");
                    bad++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_m_tuser !== want.member) begin
                        $error("is_member: expected %0d, got %0d", want.member, i_m_tuser);
                        bad++;
                    end
                    if (i_m_tdata[TOTAL_W-1:0] !== want.total) begin
                        $error("set_bit_total: expected %0d, got %0d", want.total,
                               i_m_tdata[TOTAL_W-1:0]);
                        bad++;
                    end
                end
                o_answered <= o_answered + 1;
            end
            o_fails <= o_fails + bad;
        end
        o_due <= answers_due.size();
    end
endmodule

FILE: test/tb_top.sv
module tb_top;
    import bfdh_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASES = 10;
    localparam int PHASE_BEATS = 85;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [1:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int fails;
    int due;
    int answered;
    int cycles = 0;
    int beats_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;

    // Hash pairs already inserted, so that queries can find members.
    logic [127:0] inserted_keys[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    bloom_filter_double_hash_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    bloom_check u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_fails(fails), .o_due(due), .o_answered(answered)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver switches at random among four stall patterns.
    always @(posedge i_clk) begin
        if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycles / 8) % 2 == 0);
        endcase
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input t_cmd cmd, input logic [63:0] base, input logic [63:0] stride);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {stride, base};
        s_tuser <= cmd;
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
        if (cmd == CMD_INSERT) begin
            inserted_keys.push_back({stride, base});
            if (inserted_keys.size() > 64) void'(inserted_keys.pop_front());
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves valid high so that writes can follow back to back; the caller drops it.
    task automatic write_reg(input t_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic random_beat();
        int          pick;
        logic [127:0] key;
        pick = $urandom_range(0, 199);
        if (pick == 0) begin
            send_beat(CMD_CLEAR, rand_word(), rand_word());
        end else if (pick < 5) begin
            send_beat(CMD_NONE, rand_word(), rand_word());
        end else if (pick < 95) begin
            send_beat(CMD_INSERT, rand_word(), rand_word());
        end else if (pick < 150 && inserted_keys.size() != 0) begin
            key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            send_beat(CMD_QUERY, key[63:0], key[127:64]);
        end else begin
            send_beat(CMD_QUERY, rand_word(), rand_word());
        end
    endtask

    initial begin
        static int hash_settings [PHASES] = '{7, 1, 32, 0, 63, 5, 13, 3, 2, 4};
        static int bucket_settings [PHASES] = '{65536, 8, 65536, 64, 131071, 3, 100, 1000, 0, 257};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset settings: extreme words, every command,
        // the unused command and a clear.
        send_beat(CMD_QUERY, 64'd0, 64'd0);
        send_beat(CMD_INSERT, 64'd0, 64'd0);
        send_beat(CMD_QUERY, 64'd0, 64'd0);
        send_beat(CMD_INSERT, '1, '1);
        send_beat(CMD_QUERY, '1, '1);
        send_beat(CMD_INSERT, 64'h8000_0000_0000_0000, 64'h0000_0000_0001_0000);
        send_beat(CMD_QUERY, 64'h8000_0000_0000_0000, 64'h0000_0000_0001_0000);
        send_beat(CMD_QUERY, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_beat(CMD_NONE, '1, '1);
        send_beat(CMD_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_beat(CMD_CLEAR, 64'd0, 64'd0);
        send_beat(CMD_QUERY, '1, '1);
        send_beat(CMD_INSERT, 64'd12345, 64'd0);
        send_beat(CMD_NONE, 64'd0, 64'd0);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_reg(REG_HASH_COUNT, CFG_DATA_W'(hash_settings[p]));
            write_reg(REG_BUCKET_COUNT, CFG_DATA_W'(bucket_settings[p]));
            cfg_valid <= 1'b0;
            // Bits left over from the previous setting stay counted.
            send_beat(CMD_QUERY, rand_word(), rand_word());
            for (int n = 0; n < PHASE_BEATS; n++) random_beat();
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d beats over %0d register settings; %0d results checked.",
                 beats_sent, PHASES + 1, answered);
        if (fails == 0 && due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: bloom_filter_double_hash_core.f
+incdir+sv
sv/bfdh_pkg.sv
sv/bfdh_mod_unit.sv
sv/bfdh_datapath.sv
sv/bfdh_ctrl.sv
sv/bloom_filter_double_hash_core.sv
test/bloom_check.sv
test/tb_top.sv
